// File: sv/jaap_pkg.sv
// Package with shared constants, types and tables for the joint angle to actuator position unit.
package jaap_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 13;
  localparam int TABLE_LEN = 24;
  localparam int ZW = 34;
  localparam int XW = 32;

  localparam logic signed [ZW-1:0] OFFSET_Q30 = 34'sd1547573354;
  localparam logic signed [ZW-1:0] PI_Q30 = 34'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [XW-1:0] GAIN_Q30 = 32'sd652032874;
  localparam logic signed [24:0] COEF_Q16 = 25'sd10629939;

  localparam logic [0:0] CFG_RETRACT_LEN = 1'b0;
  localparam logic [0:0] CFG_STROKE_EXTENT = 1'b1;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 neg;
  } cordic_t;

  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic signed [ZW-1:0] t;
    unique case (i)
      0: t = 34'sd843314857;  1: t = 34'sd497837829;
      2: t = 34'sd263043837;  3: t = 34'sd133525159;
      4: t = 34'sd67021687;   5: t = 34'sd33543516;
      6: t = 34'sd16775851;   7: t = 34'sd8388437;
      8: t = 34'sd4194283;    9: t = 34'sd2097149;
      default: t = ZW'(34'sd1 <<< (30 - i));
    endcase
    return t;
  endfunction

endpackage

// File: sv/jaap_cordic_cell.sv
// One CORDIC rotation stage with its valid flag.
module jaap_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_i,
  input  jaap_pkg::cordic_t d_i,
  output logic              vld_o,
  output jaap_pkg::cordic_t d_o
);
  import jaap_pkg::*;

  logic              vld_r;
  cordic_t           d_r, d_nxt;
  logic signed [XW-1:0] xs, ys;

  always_comb begin
    xs = d_i.x >>> STAGE;
    ys = d_i.y >>> STAGE;
    d_nxt = d_i;
    if (!d_i.z[ZW-1]) begin
      d_nxt.x = d_i.x - ys;
      d_nxt.y = d_i.y + xs;
      d_nxt.z = d_i.z - atan_q30(STAGE);
    end else begin
      d_nxt.x = d_i.x + ys;
      d_nxt.y = d_i.y - xs;
      d_nxt.z = d_i.z + atan_q30(STAGE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign vld_o = vld_r;
  assign d_o = d_r;
endmodule

// File: sv/jaap_sqrt_cell.sv
// One restoring square root step, two radicand bits per stage.
module jaap_sqrt_cell #(
  parameter int STAGE = 0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        vld_i,
  input  logic [25:0] v_i,
  input  logic [25:0] rem_i,
  input  logic [12:0] r_i,
  output logic        vld_o,
  output logic [25:0] v_o,
  output logic [25:0] rem_o,
  output logic [12:0] r_o
);
  localparam int SH = 25 - 2 * STAGE;

  logic        vld_r;
  logic [25:0] v_r;
  logic [25:0] rem_r, rem_nxt, trial;
  logic [12:0] r_r, r_nxt;

  always_comb begin
    trial = {rem_i[23:0], v_i[SH -: 2]} - {11'd0, r_i, 2'b01};
    if (!trial[25]) begin
      rem_nxt = trial;
      r_nxt = {r_i[11:0], 1'b1};
    end else begin
      rem_nxt = {rem_i[23:0], v_i[SH -: 2]};
      r_nxt = {r_i[11:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
    if (en) begin
      v_r <= v_i;
      rem_r <= rem_nxt;
      r_r <= r_nxt;
    end
  end

  assign vld_o = vld_r;
  assign v_o = v_r;
  assign rem_o = rem_r;
  assign r_o = r_r;
endmodule

// File: sv/jaap_div_cell.sv
// One restoring division step producing one quotient bit.
module jaap_div_cell (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        vld_i,
  input  logic        sat_i,
  input  logic [10:0] q_i,
  input  logic [27:0] rem_i,
  input  logic [27:0] den_i,
  input  logic        num_bit_i,
  output logic        vld_o,
  output logic        sat_o,
  output logic [10:0] q_o,
  output logic [27:0] rem_o,
  output logic [27:0] den_o
);
  logic        vld_r, sat_r;
  logic [10:0] q_r;
  logic [27:0] rem_r, den_r, sh;
  logic [28:0] diff;

  always_comb begin
    sh = {rem_i[26:0], num_bit_i};
    diff = {1'b0, sh} - {1'b0, den_i};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
    if (en) begin
      sat_r <= sat_i;
      den_r <= den_i;
      q_r <= {q_i[9:0], !diff[28]};
      rem_r <= diff[28] ? sh : diff[27:0];
    end
  end

  assign vld_o = vld_r;
  assign sat_o = sat_r;
  assign q_o = q_r;
  assign rem_o = rem_r;
  assign den_o = den_r;
endmodule

// File: sv/joint_angle_to_actuator_position_unit.sv
// Top level of the joint angle to actuator position unit.
// A request passes through at most 24 CORDIC stages on its way to the result.
// Throughput: one request per cycle; the pipeline stalls as a whole on out_tready.
// The rate is set by the chain of CORDIC, square root and divider cells, one step each.
// Reset (synchronous, rst_n low) clears valid flags; retracted length 0, stroke extent 256.
module joint_angle_to_actuator_position_unit #(
  parameter int CORDIC_STAGES = jaap_pkg::CORDIC_STAGES_DEF,
  parameter int ANGLE_FRAC_BITS = jaap_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // joint_angle[15:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // position[9:0], zero fill[15:10]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import jaap_pkg::*;

  localparam int NS = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

  logic        en;
  logic [15:0] base_r, ext_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= 16'd0;
      ext_r <= 16'd256;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_RETRACT_LEN:   base_r <= cfg_data;
        CFG_STROKE_EXTENT: ext_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic out_vld_r;
  logic [9:0] pos_r;
  assign en = !out_vld_r || out_tready;
  assign in_tready = en;

  // Angle reduction stage.
  logic signed [ZW-1:0] ang, th, z0;
  cordic_t c_in;
  logic v0_r;
  cordic_t c0_r;
  always_comb begin
    ang = ZW'($signed(in_tdata)) <<< (30 - ANGLE_FRAC_BITS);
    th = OFFSET_Q30 - ang;
    if (th > PI_Q30) z0 = th - (PI_Q30 <<< 1);
    else if (th < -PI_Q30) z0 = th + (PI_Q30 <<< 1);
    else z0 = th;
    c_in.x = GAIN_Q30;
    c_in.y = '0;
    c_in.neg = 1'b0;
    c_in.z = z0;
    if (z0 > HALF_PI_Q30) begin
      c_in.z = PI_Q30 - z0;
      c_in.neg = 1'b1;
    end else if (z0 < -HALF_PI_Q30) begin
      c_in.z = -PI_Q30 - z0;
      c_in.neg = 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (en) v0_r <= in_tvalid;
    if (en) c0_r <= c_in;
  end

  logic    cv [NS+1];
  cordic_t cd [NS+1];
  assign cv[0] = v0_r;
  assign cd[0] = c0_r;
  for (genvar g = 0; g < NS; g++) begin : g_cordic
    jaap_cordic_cell #(.STAGE(g)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .vld_i(cv[g]), .d_i(cd[g]),
      .vld_o(cv[g+1]), .d_o(cd[g+1]));
  end

  // Multiply by coefficient.
  logic signed [XW-1:0] cosv;
  logic signed [56:0] prod_r;
  logic vm_r;
  assign cosv = cd[NS].neg ? -cd[NS].x : cd[NS].x;
  always_ff @(posedge clk) begin
    if (!rst_n) vm_r <= 1'b0;
    else if (en) vm_r <= cv[NS];
    if (en) prod_r <= 57'(cosv) * 57'(COEF_Q16) + (57'sd1 <<< 29);
  end

  logic signed [27:0] sq;
  logic [24:0] sq_r;
  logic vs_r;
  assign sq = 28'sd16777216 - 28'(prod_r >>> 30);
  always_ff @(posedge clk) begin
    if (!rst_n) vs_r <= 1'b0;
    else if (en) vs_r <= vm_r;
    if (en) sq_r <= sq[27] ? 25'd0 : sq[24:0];
  end

  // The radicand gets a zero top bit so that it splits into thirteen bit pairs.
  logic        sv_ [14];
  logic [25:0] svv [14];
  logic [25:0] srem [14];
  logic [12:0] sr [14];
  assign sv_[0] = vs_r;
  assign svv[0] = {1'b0, sq_r};
  assign srem[0] = '0;
  assign sr[0] = '0;
  for (genvar g = 0; g < 13; g++) begin : g_sqrt
    jaap_sqrt_cell #(.STAGE(g)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .vld_i(sv_[g]), .v_i(svv[g]),
      .rem_i(srem[g]), .r_i(sr[g]), .vld_o(sv_[g+1]), .v_o(svv[g+1]),
      .rem_o(srem[g+1]), .r_o(sr[g+1]));
  end

  // Rounding of the root.
  logic [12:0] rt;
  logic [12:0] len, len_r;
  logic        vl_r;
  assign rt = sr[13];
  assign len = (srem[13] > {13'd0, rt}) ? rt + 13'd1 : rt;
  always_ff @(posedge clk) begin
    if (!rst_n) vl_r <= 1'b0;
    else if (en) vl_r <= sv_[13];
    if (en) len_r <= len;
  end

  // Diff, numerator and saturation.
  logic signed [17:0] diff;
  logic signed [27:0] num;
  logic [16:0] ext;
  logic        vd_r, sat_hi_r, sat_lo_r;
  logic [27:0] num_r, den_r;
  always_comb begin
    ext = (ext_r == 16'd0) ? 17'd1 : {1'b0, ext_r};
    diff = $signed({5'd0, len_r}) - $signed({2'b0, base_r});
    num = 28'(diff) * 28'sd1000;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) vd_r <= 1'b0;
    else if (en) vd_r <= vl_r;
    if (en) begin
      sat_lo_r <= num <= $signed(28'(ext) * 28'sd10);
      sat_hi_r <= num >= $signed(28'(ext) * 28'sd1000);
      num_r <= 28'(num <<< 1) + 28'(ext);
      den_r <= 28'(ext) << 1;
    end
  end

  // The remainder starts from the numerator bits above the ten quotient bits.
  logic        dv [11];
  logic        ds [11];
  logic [10:0] dq [11];
  logic [27:0] dr [11];
  logic [27:0] dd [11];
  logic [27:0] dn [11];
  assign dv[0] = vd_r;
  assign ds[0] = sat_lo_r;
  assign dq[0] = '0;
  assign dr[0] = {10'd0, num_r[27:10]};
  assign dd[0] = den_r;
  assign dn[0] = num_r;
  for (genvar g = 0; g < 10; g++) begin : g_div
    logic [27:0] n_r;
    jaap_div_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .vld_i(dv[g]), .sat_i(ds[g]),
      .q_i(dq[g]), .rem_i(dr[g]), .den_i(dd[g]), .num_bit_i(dn[g][9 - g]),
      .vld_o(dv[g+1]), .sat_o(ds[g+1]), .q_o(dq[g+1]), .rem_o(dr[g+1]), .den_o(dd[g+1]));
    always_ff @(posedge clk) if (en) n_r <= dn[g];
    assign dn[g+1] = n_r;
  end

  logic hi_d [11];
  assign hi_d[0] = sat_hi_r;
  for (genvar g = 0; g < 10; g++) begin : g_hi
    logic h_r;
    always_ff @(posedge clk) if (en) h_r <= hi_d[g];
    assign hi_d[g+1] = h_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (en) out_vld_r <= dv[10];
    if (en) begin
      if (ds[10]) pos_r <= 10'd10;
      else if (hi_d[10]) pos_r <= 10'd1000;
      else pos_r <= dq[10][9:0];
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata = {6'd0, pos_r};
endmodule
